[sv/ffpa_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ffpa_pkg
// Shared types and constants of the first-fit page allocator: table geometry,
// field widths, result and mode codes and the request, result and table entry types.
// ----------------------------------------------------------------------------
package ffpa_pkg;

   localparam int NUM_PAGES  = 64;
   localparam int PAGE_BYTES = 4096;
   localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
   localparam int PAGE_W     = $clog2(NUM_PAGES);
   localparam int CNT_W      = $clog2(NUM_PAGES + 1);
   localparam int BYTES_W    = 19;
   localparam int NEED_W     = BYTES_W - PAGE_SHIFT + 1;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_TOO_LARGE = 2'd1;
   localparam logic [1:0] ST_NO_RUN    = 2'd2;
   localparam logic [1:0] ST_NOTHING   = 2'd3;

   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   typedef struct packed {
      logic                 mode;
      logic [BYTES_W-1:0]   request_bytes;
      logic [PAGE_W-1:0]    free_page;
   } req_type;

   typedef struct packed {
      logic [1:0]           status;
      logic [PAGE_W-1:0]    first_page;
      logic [CNT_W-1:0]     free_pages;
      logic [BYTES_W-1:0]   free_bytes;
   } rsp_type;

   typedef struct packed {
      logic                 used;
      logic [CNT_W-1:0]     run_pages;
      logic [BYTES_W-1:0]   run_bytes;
   } entry_type;

endpackage
`default_nettype wire

[sv/first_fit_page_allocator.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_page_allocator
// Allocates and frees runs of contiguous pages, first fit, from one table.
// ----------------------------------------------------------------------------
// After reset the block clears every page table entry and takes no request
// until it is done. The whole page table (used bit, run length and byte count
// per page) sits in one single-port-write memory with a registered read, and
// one request is worked at a time. An allocation that does not fit the free
// counters goes to its reply without a scan; otherwise the scan reads one page
// per cycle from page 0 until the first fitting run is found or the table
// ends, then writes the run back one page per cycle. A free reads the entry
// at the given page, checks its run length and then clears that run.
// A new request is taken while the previous result still waits on rsp.
// ----------------------------------------------------------------------------
module first_fit_page_allocator (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_ready,
   input  wire ffpa_pkg::req_type req_data,
   output logic                rsp_valid,
   input  wire                 rsp_ready,
   output ffpa_pkg::rsp_type   rsp_data
);

   localparam int LIM_W = ffpa_pkg::CNT_W + ffpa_pkg::PAGE_SHIFT;

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_SCAN, S_ALLOC, S_FREE_RD, S_FREE_CHK, S_FREE_WR, S_REPLY
   } state_type;

   ffpa_pkg::entry_type page_mem_ff [ffpa_pkg::NUM_PAGES];
   ffpa_pkg::entry_type rd_data_ff;

   state_type                          state_ff;
   ffpa_pkg::req_type                  req_ff;
   ffpa_pkg::rsp_type                  rsp_ff;
   logic                               rsp_valid_ff;
   logic [ffpa_pkg::CNT_W-1:0]         pages_left_ff;
   logic [ffpa_pkg::BYTES_W-1:0]       bytes_left_ff;
   logic [ffpa_pkg::CNT_W-1:0]         need_ff;
   logic [ffpa_pkg::PAGE_W-1:0]        start_ff;
   logic [1:0]                         status_ff;
   logic [ffpa_pkg::PAGE_W-1:0]        wr_page_ff;
   logic [ffpa_pkg::CNT_W-1:0]         wr_left_ff;
   logic [ffpa_pkg::PAGE_W-1:0]        scan_addr_ff;
   logic [ffpa_pkg::PAGE_W-1:0]        pend_page_ff;
   logic                               pend_ff;
   logic [ffpa_pkg::CNT_W-1:0]         run_len_ff;
   logic [ffpa_pkg::PAGE_W-1:0]        run_start_ff;

   logic                               wr_en;
   ffpa_pkg::entry_type                wr_data;
   logic [ffpa_pkg::PAGE_W-1:0]        rd_addr;
   logic [ffpa_pkg::NEED_W-1:0]        need_full;
   logic                               too_large;
   logic                               cur_free;
   logic [ffpa_pkg::CNT_W-1:0]         run_len_in;
   logic                               found;
   logic [ffpa_pkg::PAGE_W-1:0]        cand_start;
   logic                               rsp_load;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign need_full = ffpa_pkg::NEED_W'(req_data.request_bytes >> ffpa_pkg::PAGE_SHIFT)
                    + ffpa_pkg::NEED_W'(1);
   assign too_large = (req_data.request_bytes > bytes_left_ff)
                    || (need_full > ffpa_pkg::NEED_W'(pages_left_ff));

   assign cur_free   = !rd_data_ff.used;
   assign run_len_in = cur_free ? run_len_ff + ffpa_pkg::CNT_W'(1) : '0;
   assign found      = pend_ff && cur_free && (run_len_in == need_ff);
   assign cand_start = (run_len_ff == '0) ? pend_page_ff : run_start_ff;
   assign rsp_load   = (state_ff == S_REPLY) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      wr_en   = 1'b0;
      wr_data = '0;
      rd_addr = req_ff.free_page;
      case (state_ff)
         S_CLEAR, S_FREE_WR: begin
            wr_en = 1'b1;
         end
         S_ALLOC: begin
            wr_en        = 1'b1;
            wr_data.used = 1'b1;
            if (wr_page_ff == start_ff) begin
               wr_data.run_pages = need_ff;
               wr_data.run_bytes = req_ff.request_bytes;
            end
         end
         S_SCAN: begin
            rd_addr = scan_addr_ff;
         end
         default: begin
         end
      endcase
   end

   // page table
   always_ff @(posedge clock) begin
      if (wr_en) begin
         page_mem_ff[wr_page_ff] <= wr_data;
      end
      rd_data_ff <= page_mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         rsp_valid_ff  <= 1'b0;
         pages_left_ff <= ffpa_pkg::CNT_W'(ffpa_pkg::NUM_PAGES);
         bytes_left_ff <= ffpa_pkg::BYTES_W'(ffpa_pkg::NUM_PAGES * ffpa_pkg::PAGE_BYTES);
         wr_page_ff    <= '0;
         pend_ff       <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_CLEAR: begin
               wr_page_ff <= wr_page_ff + ffpa_pkg::PAGE_W'(1);
               if (wr_page_ff == ffpa_pkg::PAGE_W'(ffpa_pkg::NUM_PAGES - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_valid) begin
                  req_ff   <= req_data;
                  start_ff <= '0;
                  if (req_data.mode == ffpa_pkg::MODE_FREE) begin
                     state_ff <= S_FREE_RD;
                  end else if (too_large) begin
                     status_ff <= ffpa_pkg::ST_TOO_LARGE;
                     state_ff  <= S_REPLY;
                  end else begin
                     need_ff      <= ffpa_pkg::CNT_W'(need_full);
                     scan_addr_ff <= '0;
                     pend_ff      <= 1'b0;
                     run_len_ff   <= '0;
                     state_ff     <= S_SCAN;
                  end
               end
            end
            S_SCAN: begin
               scan_addr_ff <= scan_addr_ff + ffpa_pkg::PAGE_W'(1);
               pend_page_ff <= scan_addr_ff;
               pend_ff      <= 1'b1;
               if (pend_ff) begin
                  run_len_ff <= run_len_in;
                  if (cur_free && run_len_ff == '0) begin
                     run_start_ff <= pend_page_ff;
                  end
               end
               if (found) begin
                  start_ff   <= cand_start;
                  wr_page_ff <= cand_start;
                  wr_left_ff <= need_ff;
                  state_ff   <= S_ALLOC;
               end else if (pend_ff
                  && pend_page_ff == ffpa_pkg::PAGE_W'(ffpa_pkg::NUM_PAGES - 1)) begin
                  status_ff <= ffpa_pkg::ST_NO_RUN;
                  state_ff  <= S_REPLY;
               end
            end
            S_ALLOC: begin
               wr_page_ff <= wr_page_ff + ffpa_pkg::PAGE_W'(1);
               wr_left_ff <= wr_left_ff - ffpa_pkg::CNT_W'(1);
               if (wr_left_ff == ffpa_pkg::CNT_W'(1)) begin
                  pages_left_ff <= pages_left_ff - need_ff;
                  bytes_left_ff <= bytes_left_ff - req_ff.request_bytes;
                  status_ff     <= ffpa_pkg::ST_OK;
                  state_ff      <= S_REPLY;
               end
            end
            S_FREE_RD: begin
               state_ff <= S_FREE_CHK;
            end
            S_FREE_CHK: begin
               if (rd_data_ff.run_pages == '0) begin
                  status_ff <= ffpa_pkg::ST_NOTHING;
                  state_ff  <= S_REPLY;
               end else begin
                  pages_left_ff <= pages_left_ff + rd_data_ff.run_pages;
                  bytes_left_ff <= bytes_left_ff + rd_data_ff.run_bytes;
                  wr_page_ff    <= req_ff.free_page;
                  wr_left_ff    <= rd_data_ff.run_pages;
                  status_ff     <= ffpa_pkg::ST_OK;
                  state_ff      <= S_FREE_WR;
               end
            end
            S_FREE_WR: begin
               wr_page_ff <= wr_page_ff + ffpa_pkg::PAGE_W'(1);
               wr_left_ff <= wr_left_ff - ffpa_pkg::CNT_W'(1);
               if (wr_left_ff == ffpa_pkg::CNT_W'(1)) begin
                  state_ff <= S_REPLY;
               end
            end
            S_REPLY: begin
               if (rsp_load) begin
                  rsp_ff.status     <= status_ff;
                  rsp_ff.first_page <= start_ff;
                  rsp_ff.free_pages <= pages_left_ff;
                  rsp_ff.free_bytes <= bytes_left_ff;
                  state_ff          <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   a_pages_bound: assert property (@(posedge clock) disable iff (reset)
      pages_left_ff <= ffpa_pkg::CNT_W'(ffpa_pkg::NUM_PAGES))
      else $error("free page count beyond table size");

   a_bytes_cover: assert property (@(posedge clock) disable iff (reset)
      (LIM_W'(pages_left_ff) << ffpa_pkg::PAGE_SHIFT) <= LIM_W'(bytes_left_ff))
      else $error("free bytes below free pages times page size");

   a_fail_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status != ffpa_pkg::ST_OK |-> rsp_ff.first_page == '0)
      else $error("failed request reports a first page");

   a_scan_hold: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN && pend_ff |-> run_len_ff < need_ff)
      else $error("scan ran past a fitting run");

endmodule
`default_nettype wire

[test/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Checks the first-fit page allocator against a cycle-free model of its page
// table: a short list of directed requests, then randomised allocate and
// free traffic with random idling on both channels and one long result stall.
// ----------------------------------------------------------------------------
module testbench;

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int RANDOM_ITEMS = 950;
   localparam int QUIET_ITEMS  = 120;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 200;

   typedef struct {
      ffpa_pkg::req_type rq;
      bit                typed;
      ffpa_pkg::rsp_type rs;
   } row_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   ffpa_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   ffpa_pkg::rsp_type rsp_data;

   ffpa_pkg::rsp_type offered_rsp;
   ffpa_pkg::rsp_type want_rsp;
   ffpa_pkg::rsp_type expected_rsps[$];
   row_type           directed_rows[$];

   bit pg_used[ffpa_pkg::NUM_PAGES];
   int run_len[ffpa_pkg::NUM_PAGES];
   int run_size[ffpa_pkg::NUM_PAGES];
   int pages_free;
   int bytes_free;

   int errors = 0;
   int cycle_count = 0;
   bit quiet = 1'b0;
   bit hold_off_req = 1'b0;

   first_fit_page_allocator DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   function automatic ffpa_pkg::rsp_type allocate_or_free(ffpa_pkg::req_type r);
      ffpa_pkg::rsp_type o;
      int need;
      int s;
      int pg;
      bit found;
      bit fits;
      o = '0;
      o.status = ffpa_pkg::ST_OK;
      if (r.mode == ffpa_pkg::MODE_ALLOC) begin
         need = int'(r.request_bytes) / ffpa_pkg::PAGE_BYTES + 1;
         if (int'(r.request_bytes) > bytes_free || need > pages_free
             || need > ffpa_pkg::NUM_PAGES) begin
            o.status = ffpa_pkg::ST_TOO_LARGE;
         end else begin
            found = 1'b0;
            s = 0;
            for (int c = 0; c + need <= ffpa_pkg::NUM_PAGES && !found; c++) begin
               fits = 1'b1;
               for (int k = 0; k < need; k++) begin
                  if (pg_used[c + k]) fits = 1'b0;
               end
               if (fits) begin
                  found = 1'b1;
                  s = c;
               end
            end
            if (!found) begin
               o.status = ffpa_pkg::ST_NO_RUN;
            end else begin
               for (int k = 0; k < need; k++) pg_used[s + k] = 1'b1;
               run_len[s] = need;
               run_size[s] = int'(r.request_bytes);
               pages_free -= need;
               bytes_free -= int'(r.request_bytes);
               o.first_page = s[ffpa_pkg::PAGE_W-1:0];
            end
         end
      end else begin
         pg = int'(r.free_page);
         if (pg >= ffpa_pkg::NUM_PAGES || run_len[pg] == 0) begin
            o.status = ffpa_pkg::ST_NOTHING;
         end else begin
            need = run_len[pg];
            pages_free += need;
            bytes_free += run_size[pg];
            for (int k = 0; k < need && pg + k < ffpa_pkg::NUM_PAGES; k++) begin
               pg_used[pg + k] = 1'b0;
               run_len[pg + k] = 0;
               run_size[pg + k] = 0;
            end
         end
      end
      o.free_pages = pages_free[ffpa_pkg::CNT_W-1:0];
      o.free_bytes = bytes_free[ffpa_pkg::BYTES_W-1:0];
      return o;
   endfunction

   function automatic row_type mk_row(logic mode, int nbytes, int page, bit typed = 1'b0,
                                      logic [1:0] st = ffpa_pkg::ST_OK, int start = 0,
                                      int fpages = 0, int fbytes = 0);
      row_type w;
      w.rq.mode = mode;
      w.rq.request_bytes = nbytes[ffpa_pkg::BYTES_W-1:0];
      w.rq.free_page = page[ffpa_pkg::PAGE_W-1:0];
      w.typed = typed;
      w.rs.status = st;
      w.rs.first_page = start[ffpa_pkg::PAGE_W-1:0];
      w.rs.free_pages = fpages[ffpa_pkg::CNT_W-1:0];
      w.rs.free_bytes = fbytes[ffpa_pkg::BYTES_W-1:0];
      return w;
   endfunction

   task automatic report_mismatch(string msg);
      errors++;
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
   endtask

   task automatic send_beat(ffpa_pkg::req_type rq, ffpa_pkg::rsp_type ex);
      int gap;
      gap = (!quiet && $urandom_range(0, 99) < 30) ? $urandom_range(1, 17) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= rq;
      offered_rsp <= ex;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("first_fit_page_allocator verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) expected_rsps.push_back(offered_rsp);
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsps.size() == 0) begin
            report_mismatch($sformatf("result %h with nothing outstanding", rsp_data));
         end else begin
            want_rsp = expected_rsps.pop_front();
            if (rsp_data.status !== want_rsp.status)
               report_mismatch($sformatf("status %0d, want %0d",
                                         rsp_data.status, want_rsp.status));
            if (rsp_data.first_page !== want_rsp.first_page)
               report_mismatch($sformatf("first_page %0d, want %0d",
                                         rsp_data.first_page, want_rsp.first_page));
            if (rsp_data.free_pages !== want_rsp.free_pages)
               report_mismatch($sformatf("free_pages %0d, want %0d",
                                         rsp_data.free_pages, want_rsp.free_pages));
            if (rsp_data.free_bytes !== want_rsp.free_bytes)
               report_mismatch($sformatf("free_bytes %0d, want %0d",
                                         rsp_data.free_bytes, want_rsp.free_bytes));
         end
      end
   end

   initial begin
      rsp_ready = 1'b0;
      @(posedge clock);
      forever begin
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (!quiet && $urandom_range(0, 99) < 30) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end
      end
   end

   initial begin
      ffpa_pkg::req_type rq;
      ffpa_pkg::rsp_type ex;
      int k;
      int m;
      int nb;
      int live[$];

      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      offered_rsp = '0;
      for (int p = 0; p < ffpa_pkg::NUM_PAGES; p++) begin
         pg_used[p] = 1'b0;
         run_len[p] = 0;
         run_size[p] = 0;
      end
      pages_free = ffpa_pkg::NUM_PAGES;
      bytes_free = ffpa_pkg::NUM_PAGES * ffpa_pkg::PAGE_BYTES;

      directed_rows.push_back(mk_row(ffpa_pkg::MODE_FREE, 0, 0, 1, ffpa_pkg::ST_NOTHING,
                                     0, 64, 262144));
      directed_rows.push_back(mk_row(ffpa_pkg::MODE_ALLOC, 524287, 0, 1,
                                     ffpa_pkg::ST_TOO_LARGE, 0, 64, 262144));
      directed_rows.push_back(mk_row(ffpa_pkg::MODE_ALLOC, 262144, 0, 1,
                                     ffpa_pkg::ST_TOO_LARGE, 0, 64, 262144));
      directed_rows.push_back(mk_row(ffpa_pkg::MODE_ALLOC, 0, 63, 1, ffpa_pkg::ST_OK,
                                     0, 63, 262144));
      directed_rows.push_back(mk_row(ffpa_pkg::MODE_FREE, 524287, 0, 1, ffpa_pkg::ST_OK,
                                     0, 64, 262144));
      directed_rows.push_back(mk_row(ffpa_pkg::MODE_ALLOC, 262143, 0, 1, ffpa_pkg::ST_OK,
                                     0, 0, 1));
      directed_rows.push_back(mk_row(ffpa_pkg::MODE_ALLOC, 0, 0, 1, ffpa_pkg::ST_TOO_LARGE,
                                     0, 0, 1));
      directed_rows.push_back(mk_row(ffpa_pkg::MODE_FREE, 0, 63, 1, ffpa_pkg::ST_NOTHING,
                                     0, 0, 1));
      directed_rows.push_back(mk_row(ffpa_pkg::MODE_FREE, 0, 0, 1, ffpa_pkg::ST_OK,
                                     0, 64, 262144));
      directed_rows.push_back(mk_row(ffpa_pkg::MODE_ALLOC, 4095, 0));
      directed_rows.push_back(mk_row(ffpa_pkg::MODE_ALLOC, 4096, 0));
      directed_rows.push_back(mk_row(ffpa_pkg::MODE_ALLOC, 8191, 0));
      directed_rows.push_back(mk_row(ffpa_pkg::MODE_FREE, 0, 1));
      directed_rows.push_back(mk_row(ffpa_pkg::MODE_ALLOC, 0, 0));
      directed_rows.push_back(mk_row(ffpa_pkg::MODE_ALLOC, 8192, 0));
      directed_rows.push_back(mk_row(ffpa_pkg::MODE_FREE, 0, 2));
      directed_rows.push_back(mk_row(ffpa_pkg::MODE_FREE, 0, 6));
      directed_rows.push_back(mk_row(ffpa_pkg::MODE_FREE, 0, 0));
      directed_rows.push_back(mk_row(ffpa_pkg::MODE_FREE, 0, 3));
      directed_rows.push_back(mk_row(ffpa_pkg::MODE_FREE, 0, 5));
      directed_rows.push_back(mk_row(ffpa_pkg::MODE_ALLOC, 253952, 0, 1,
                                     ffpa_pkg::ST_NO_RUN, 0, 63, 262144));
      directed_rows.push_back(mk_row(ffpa_pkg::MODE_ALLOC, 249856, 0));
      directed_rows.push_back(mk_row(ffpa_pkg::MODE_FREE, 0, 2));
      directed_rows.push_back(mk_row(ffpa_pkg::MODE_FREE, 0, 1));

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         ex = allocate_or_free(directed_rows[i].rq);
         if (directed_rows[i].typed) ex = directed_rows[i].rs;
         send_beat(directed_rows[i].rq, ex);
      end

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == 40) hold_off_req = 1'b1;
         if (i == RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
         rq.request_bytes = ffpa_pkg::BYTES_W'($urandom);
         rq.free_page = ffpa_pkg::PAGE_W'($urandom_range(0, ffpa_pkg::NUM_PAGES - 1));
         k = $urandom_range(0, 99);
         if (k < 50) begin
            rq.mode = ffpa_pkg::MODE_ALLOC;
            m = $urandom_range(0, 99);
            if (m < 55) nb = $urandom_range(0, 16383);
            else if (m < 75) nb = $urandom_range(0, 65535);
            else if (m < 85) nb = $urandom & 32'h7FFFF;
            else begin
               nb = $urandom_range(0, 20) * ffpa_pkg::PAGE_BYTES - $urandom_range(0, 1);
               if (nb < 0) nb = 0;
            end
            rq.request_bytes = nb[ffpa_pkg::BYTES_W-1:0];
         end else begin
            rq.mode = ffpa_pkg::MODE_FREE;
            if (k < 90) begin
               live.delete();
               for (int p = 0; p < ffpa_pkg::NUM_PAGES; p++) begin
                  if (run_len[p] != 0) live.push_back(p);
               end
               if (live.size() != 0)
                  rq.free_page = ffpa_pkg::PAGE_W'(live[$urandom_range(0, live.size() - 1)]);
            end
         end
         ex = allocate_or_free(rq);
         send_beat(rq, ex);
      end

      req_valid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (errors == 0) $display("first_fit_page_allocator verification clean");
      else $display("first_fit_page_allocator verification failed");
      $finish;
   end

endmodule

[first_fit_page_allocator.f]
sv/ffpa_pkg.sv
sv/first_fit_page_allocator.sv
test/testbench.sv
